@@ rtl/bdm_pkg.sv @@
// Shared types, widths and the restoring-divide step for the block distribution mapper.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int STEP_W      = $clog2(COUNT_WIDTH);
    localparam int CFG_IDX_W   = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ITEMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // configuration values plus the sizes and split derived from them
    typedef struct packed {
        count_t total;
        count_t groups;
        count_t small_sz;
        count_t extra;
        count_t large_sz;
        count_t split;
    } bdm_cfg_t;

    // one beat traveling down the divide pipeline
    typedef struct packed {
        logic   err;
        count_t quo;
        count_t rem;
        count_t dvs;
        count_t off;
        count_t idx;
    } div_beat_t;

    typedef struct packed {
        count_t rem;
        count_t quo;
    } div_step_t;

    // One restoring step: shift the next dividend bit into the remainder,
    // subtract the divisor when it fits and record the quotient bit.
    function automatic div_step_t div_step(input count_t rem, input count_t quo,
                                           input count_t dvs);
        logic [COUNT_WIDTH:0] trial;
        logic [COUNT_WIDTH:0] diff;
        div_step_t            res;
        trial   = {rem, quo[COUNT_WIDTH-1]};
        diff    = trial - {1'b0, dvs};
        res.quo = {quo[COUNT_WIDTH-2:0], 1'b0};
        if (trial >= {1'b0, dvs})
        begin
            res.rem    = diff[COUNT_WIDTH-1:0];
            res.quo[0] = 1'b1;
        end
        else
        begin
            res.rem = trial[COUNT_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bdm_cfg.sv @@
// Configuration registers and the sequential unit that derives group sizes from them.
// Depends on bdm_pkg (div_step, bdm_cfg_t).
`default_nettype none

module bdm_cfg
    import bdm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire count_t               cfg_data,
    output bdm_cfg_t                  cfg,
    output logic                      calc_busy
);

    localparam logic [2:0] CS_IDLE  = 3'd0;
    localparam logic [2:0] CS_LOAD  = 3'd1;
    localparam logic [2:0] CS_DIV   = 3'd2;
    localparam logic [2:0] CS_LARGE = 3'd3;
    localparam logic [2:0] CS_SPLIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    count_t                total_reg, total_next;
    count_t                groups_reg, groups_next;
    count_t                quo_reg, quo_next;
    count_t                rem_reg, rem_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    count_t                small_reg, small_next;
    count_t                extra_reg, extra_next;
    count_t                large_reg, large_next;
    count_t                split_reg, split_next;
    logic [2*COUNT_WIDTH-1:0] prod;
    div_step_t             step;

    assign step = div_step(rem_reg, quo_reg, groups_reg);
    assign prod = large_reg * extra_reg;

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        groups_next = groups_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        small_next  = small_reg;
        extra_next  = extra_reg;
        large_next  = large_reg;
        split_next  = split_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
            end
            CS_LOAD:
            begin
                quo_next   = total_reg;
                rem_next   = '0;
                cnt_next   = STEP_W'(COUNT_WIDTH - 1);
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                quo_next = step.quo;
                rem_next = step.rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = CS_LARGE;
                end
            end
            CS_LARGE:
            begin
                small_next = quo_reg;
                extra_next = rem_reg;
                large_next = quo_reg + {{(COUNT_WIDTH-1){1'b0}}, (rem_reg != '0)};
                state_next = CS_SPLIT;
            end
            CS_SPLIT:
            begin
                split_next = prod[COUNT_WIDTH-1:0];
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
        // a write restarts the derivation with the new values
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOTAL_ITEMS: total_next  = cfg_data;
                REG_GROUP_COUNT: groups_next = cfg_data;
                default:         total_next  = total_reg;
            endcase
            state_next = CS_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CS_IDLE;
            total_reg  <= '0;
            groups_reg <= COUNT_WIDTH'(1);
            small_reg  <= '0;
            extra_reg  <= '0;
            large_reg  <= '0;
            split_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            groups_reg <= groups_next;
            small_reg  <= small_next;
            extra_reg  <= extra_next;
            large_reg  <= large_next;
            split_reg  <= split_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign cfg.total    = total_reg;
    assign cfg.groups   = groups_reg;
    assign cfg.small_sz = small_reg;
    assign cfg.extra    = extra_reg;
    assign cfg.large_sz = large_reg;
    assign cfg.split    = split_reg;
    assign calc_busy    = (state_reg != CS_IDLE);

endmodule

`default_nettype wire

@@ rtl/bdm_div_stage.sv @@
// One stage of the pipelined divider: one quotient bit per stage, valid travels along.
// Depends on bdm_pkg (div_beat_t, div_step).
`default_nettype none

module bdm_div_stage
    import bdm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire div_beat_t in_beat,
    output logic           out_valid,
    output div_beat_t      out_beat
);

    logic      valid_reg;
    div_beat_t beat_reg, beat_next;
    div_step_t step;

    assign step = div_step(in_beat.rem, in_beat.quo, in_beat.dvs);

    always_comb
    begin
        beat_next     = in_beat;
        beat_next.quo = step.quo;
        beat_next.rem = step.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload needs no reset; advance it every cycle
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

@@ rtl/block_distribution_mapper_top.sv @@
// Throughput: one beat per cycle while busy is low; the pipeline of COUNT_WIDTH divide stages sets the latency.
// After each configuration write, busy stays high while a sequential divider derives the
// group sizes. The receiver cannot stall: done lasts one cycle.
// Reset (rst_n low, asynchronous) drops all beats in flight, total_items = 0, group_count = 1.
// Depends on bdm_pkg, bdm_cfg, bdm_div_stage.
`default_nettype none

module block_distribution_mapper_top
    import bdm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire count_t               item_index,
    output logic                      done,
    output count_t                    group_index,
    output count_t                    group_head,
    output count_t                    group_size,
    output logic                      error_flag,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire count_t               cfg_data
);

    localparam int ACCEPT_TO_DONE = COUNT_WIDTH + 2;

    bdm_cfg_t  cfg;
    logic      calc_busy;
    logic      accept;

    // stage 0 is the entry register, stage COUNT_WIDTH holds the finished quotient
    logic      stage_valid [0:COUNT_WIDTH];
    div_beat_t stage_beat  [0:COUNT_WIDTH];

    logic      entry_valid_reg;
    div_beat_t entry_beat_reg, entry_beat_next;
    count_t    idx_past_split;
    logic      in_large;

    logic      done_reg;
    count_t    group_index_reg, group_index_next;
    count_t    group_head_reg, group_head_next;
    count_t    group_size_reg, group_size_next;
    logic      error_flag_reg;
    div_beat_t last_beat;

    // ------------------------------------------------------------------
    // Configuration registers and derived sizes (small, extra, large, split)
    // ------------------------------------------------------------------
    bdm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .calc_busy (calc_busy)
    );

    // Hold off new beats while the sizes are being derived.
    assign busy   = calc_busy || cfg_we;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Entry stage: flag errors and choose the region of the item.
    // Items below split sit in the enlarged leading groups and divide by
    // large; the rest are offset by split, divide by small and add extra.
    // ------------------------------------------------------------------
    assign in_large       = (item_index < cfg.split);
    assign idx_past_split = item_index - cfg.split;

    always_comb
    begin
        entry_beat_next.err = (cfg.groups == '0) || (item_index >= cfg.total);
        entry_beat_next.rem = '0;
        entry_beat_next.idx = item_index;
        if (in_large)
        begin
            entry_beat_next.quo = item_index;
            entry_beat_next.dvs = cfg.large_sz;
            entry_beat_next.off = '0;
        end
        else
        begin
            entry_beat_next.quo = idx_past_split;
            entry_beat_next.dvs = cfg.small_sz;
            entry_beat_next.off = cfg.extra;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_beat_reg <= entry_beat_next;
    end

    assign stage_valid[0] = entry_valid_reg;
    assign stage_beat[0]  = entry_beat_reg;

    // ------------------------------------------------------------------
    // Divider pipeline: one quotient bit per stage, MSB first.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < COUNT_WIDTH; k++)
    begin : g_div
        bdm_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_beat   (stage_beat[k]),
            .out_valid (stage_valid[k+1]),
            .out_beat  (stage_beat[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: group = quotient + offset, head = index - remainder,
    // size = divisor. Zero everything on an error beat.
    // ------------------------------------------------------------------
    assign last_beat = stage_beat[COUNT_WIDTH];

    always_comb
    begin
        if (last_beat.err)
        begin
            group_index_next = '0;
            group_head_next  = '0;
            group_size_next  = '0;
        end
        else
        begin
            group_index_next = last_beat.quo + last_beat.off;
            group_head_next  = last_beat.idx - last_beat.rem;
            group_size_next  = last_beat.dvs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[COUNT_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        group_index_reg <= group_index_next;
        group_head_reg  <= group_head_next;
        group_size_reg  <= group_size_next;
        error_flag_reg  <= last_beat.err;
    end

    assign done        = done_reg;
    assign group_index = group_index_reg;
    assign group_head  = group_head_reg;
    assign group_size  = group_size_reg;
    assign error_flag  = error_flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // every result beat traces back to an accepted beat a fixed time earlier
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, ACCEPT_TO_DONE))
        else $error("result beat without a matching accepted beat");

    // every accepted beat comes out after the fixed latency
    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##ACCEPT_TO_DONE done)
        else $error("accepted beat lost in the pipeline");

    // a valid item never lands in an empty group
    a_valid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !error_flag) |-> (group_size != '0))
        else $error("valid item mapped to an empty group");

    // configuration derivation never overlaps an accepted beat
    a_no_accept_while_calc: assert property (@(posedge clk) disable iff (!rst_n)
        calc_busy |-> !accept)
        else $error("beat accepted while group sizes are being derived");

endmodule

`default_nettype wire
